/* design/usbsrd_pkg.sv */
package usbsrd_pkg;

   // Largest data packet on the control endpoint, in bytes (8 to 64).
   localparam int EP0_PACKET_BYTES = 64;

   // Result actions.
   localparam logic [2:0] ACT_STALL   = 3'd0;
   localparam logic [2:0] ACT_SEND    = 3'd1;
   localparam logic [2:0] ACT_STATUS  = 3'd2;
   localparam logic [2:0] ACT_FORWARD = 3'd3;
   localparam logic [2:0] ACT_NONE    = 3'd4;

   // Data sources for the send action.
   localparam logic [2:0] SRC_DEVICE   = 3'd0;
   localparam logic [2:0] SRC_CONFIG   = 3'd1;
   localparam logic [2:0] SRC_LANGUAGE = 3'd2;
   localparam logic [2:0] SRC_MANUF    = 3'd3;
   localparam logic [2:0] SRC_CDC_PROD = 3'd4;
   localparam logic [2:0] SRC_HID_PROD = 3'd5;
   localparam logic [2:0] SRC_REPLY    = 3'd6;

   // Halt update codes.
   localparam logic [1:0] HALT_NONE  = 2'd0;
   localparam logic [1:0] HALT_SET   = 2'd1;
   localparam logic [1:0] HALT_CLEAR = 2'd2;

   // Class targets.
   localparam logic CLASS_HID = 1'b0;
   localparam logic CLASS_CDC = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_HID_PRESENT = 2'd0;
   localparam logic [1:0] CSR_CDC_PRESENT = 2'd1;
   localparam logic [1:0] CSR_CONFIG_LEN  = 2'd2;

   // bmRequestType values.
   localparam logic [7:0] RT_DEV_OUT   = 8'h00;
   localparam logic [7:0] RT_IF_OUT    = 8'h01;
   localparam logic [7:0] RT_EP_OUT    = 8'h02;
   localparam logic [7:0] RT_DEV_IN    = 8'h80;
   localparam logic [7:0] RT_IF_IN     = 8'h81;
   localparam logic [7:0] RT_EP_IN     = 8'h82;
   localparam logic [4:0] RT_RECIP_IF  = 5'h01;

   // bRequest codes.
   localparam logic [7:0] REQ_GET_STATUS    = 8'd0;
   localparam logic [7:0] REQ_CLEAR_FEATURE = 8'd1;
   localparam logic [7:0] REQ_SET_FEATURE   = 8'd3;
   localparam logic [7:0] REQ_SET_ADDRESS   = 8'd5;
   localparam logic [7:0] REQ_GET_DESC      = 8'd6;
   localparam logic [7:0] REQ_GET_CONFIG    = 8'd8;
   localparam logic [7:0] REQ_SET_CONFIG    = 8'd9;
   localparam logic [7:0] REQ_GET_IFACE     = 8'd10;
   localparam logic [7:0] REQ_SET_IFACE     = 8'd11;

   // Descriptor types.
   localparam logic [7:0] DESC_DEVICE = 8'd1;
   localparam logic [7:0] DESC_CONFIG = 8'd2;
   localparam logic [7:0] DESC_STRING = 8'd3;

   // English language id bytes.
   localparam logic [7:0] LANG_ID_LOW  = 8'h09;
   localparam logic [7:0] LANG_ID_HIGH = 8'h04;

   // Endpoint addresses of the class interfaces, and of the control endpoint's IN side.
   localparam logic [7:0] EP_HID_OUT = 8'h01;
   localparam logic [7:0] EP_HID_IN  = 8'h81;
   localparam logic [7:0] EP_CDC_OUT = 8'h02;
   localparam logic [7:0] EP_CDC_IN  = 8'h82;
   localparam logic [7:0] EP_CDC_INT = 8'h83;
   localparam logic [7:0] EP_ZERO_IN = 8'h80;

   // Fixed descriptor lengths in bytes.
   localparam logic [7:0] LEN_DEVICE   = 8'd18;
   localparam logic [7:0] LEN_LANGUAGE = 8'd4;
   localparam logic [7:0] LEN_MANUF    = 8'd22;
   localparam logic [7:0] LEN_CDC_PROD = 8'd24;
   localparam logic [7:0] LEN_HID_PROD = 8'd16;
   localparam logic [7:0] LEN_BYTE     = 8'd1;
   localparam logic [7:0] LEN_WORD     = 8'd2;

   // True when a nonzero length is a whole number of full packets.
   function automatic logic is_packet_multiple(input logic [7:0] len);
      logic hit;
      hit = 1'b0;
      for (int k = 1; k <= 255 / EP0_PACKET_BYTES; k++) begin
         if (len == 8'(k * EP0_PACKET_BYTES)) hit = 1'b1;
      end
      return hit;
   endfunction

endpackage

/* design/usb_setup_request_decoder.sv */
// Channel   Direction  Handshake               Word
// req_      in         req_valid / req_ready   one setup packet or bus reset event
// rsp_      out        rsp_valid / rsp_ready   one decoded result
// csr_      in         csr_valid / csr_ready   register index and write data
//
// A word is accepted into the input register and decoded into the result
// register once that register is empty or being drained.
// A new word is accepted every cycle while results drain; with the result stalled
// the input register still takes one word, after which req_ready follows rsp_ready.
// Synchronous active-high reset clears the configuration registers, the
// configuration flag, both halt masks and the valid flags.
module usb_setup_request_decoder
   import usbsrd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [7:0]  req_request_type,
   input  logic [7:0]  req_request_code,
   input  logic [7:0]  req_value_low,
   input  logic [7:0]  req_value_high,
   input  logic [7:0]  req_index_low,
   input  logic [7:0]  req_index_high,
   input  logic [15:0] req_length_limit,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_action,
   output logic [2:0]  rsp_data_source,
   output logic [7:0]  rsp_send_length,
   output logic        rsp_send_zlp,
   output logic [15:0] rsp_reply_word,
   output logic        rsp_class_target,
   output logic        rsp_address_write,
   output logic [6:0]  rsp_new_address,
   output logic [1:0]  rsp_halt_update,
   output logic [3:0]  rsp_halt_endpoint,
   output logic        rsp_halt_is_in,
   output logic        rsp_configured,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   // Configuration registers.
   logic       hid_present_ff;
   logic       cdc_present_ff;
   logic [7:0] config_len_ff;

   // Device state.
   logic       configured_ff, configured_in;
   logic [3:0] halt_in_ff, halt_in_in;
   logic [3:0] halt_out_ff, halt_out_in;

   // Input register.
   logic        in_valid_ff;
   logic        op_ff;
   logic [7:0]  typ_ff, req_ff, val_ff, kind_ff, ix_ff, ixh_ff;
   logic [15:0] wlen_ff;

   // Result register.
   logic        out_valid_ff;
   logic [2:0]  action_ff, action_in;
   logic [2:0]  source_ff, source_in;
   logic [7:0]  length_ff, length_in;
   logic        zlp_ff, zlp_in;
   logic [15:0] word_ff, word_in;
   logic        target_ff, target_in;
   logic        addr_wr_ff, addr_wr_in;
   logic [6:0]  addr_ff, addr_in;
   logic [1:0]  halt_upd_ff, halt_upd_in;
   logic [3:0]  halt_ep_ff, halt_ep_in;
   logic        halt_dir_ff, halt_dir_in;
   logic        configured_out_ff;

   logic advance;
   logic in_load;
   logic step;

   // The result register takes a new word when it is empty or being drained.
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign in_load   = req_valid && req_ready;
   assign step      = in_valid_ff && advance;
   assign csr_ready = 1'b1;

   // Configuration writes; indexes past the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         hid_present_ff <= 1'b0;
         cdc_present_ff <= 1'b0;
         config_len_ff  <= 8'd0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_HID_PRESENT: hid_present_ff <= csr_data[0];
            CSR_CDC_PRESENT: cdc_present_ff <= csr_data[0];
            CSR_CONFIG_LEN:  config_len_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_load) begin
         in_valid_ff <= 1'b1;
      end else if (step) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         op_ff   <= req_operation;
         typ_ff  <= req_request_type;
         req_ff  <= req_request_code;
         val_ff  <= req_value_low;
         kind_ff <= req_value_high;
         ix_ff   <= req_index_low;
         ixh_ff  <= req_index_high;
         wlen_ff <= req_length_limit;
      end
   end

   // Layout checks on the interface and endpoint numbers.
   logic [1:0] iface_count;
   logic       iface_ok;
   logic       ep_ok;
   logic [3:0] ep_bit;
   logic       ep_halted;

   assign iface_count = (cdc_present_ff ? 2'd2 : 2'd0) + (hid_present_ff ? 2'd1 : 2'd0);
   assign iface_ok    = ix_ff < {6'd0, iface_count};
   assign ep_ok       = (hid_present_ff && (ix_ff == EP_HID_OUT || ix_ff == EP_HID_IN)) ||
                        (cdc_present_ff && (ix_ff == EP_CDC_OUT || ix_ff == EP_CDC_IN ||
                                            ix_ff == EP_CDC_INT));
   assign ep_bit      = 4'b0001 << ix_ff[1:0];
   assign ep_halted   = ix_ff[7] ? halt_in_ff[ix_ff[1:0]] : halt_out_ff[ix_ff[1:0]];

   // Request conditions, in the order in which they are tried.
   logic plain_zero;
   logic ixh_bad;
   logic c_desc_dev, c_desc_cfg, c_string;
   logic c_addr, c_setcfg, c_getcfg;
   logic c_stat_plain, c_stat_ep, c_feature;
   logic c_getif, c_setif, c_fwd_hid, c_fwd_cdc;
   logic get_desc;
   logic lang_ok;

   assign plain_zero = (kind_ff == 8'd0) && (val_ff == 8'd0);
   assign get_desc   = (typ_ff == RT_DEV_IN) && (req_ff == REQ_GET_DESC);
   assign lang_ok    = (ix_ff == 8'd0 && ixh_ff == 8'd0) ||
                       (ix_ff == LANG_ID_LOW && ixh_ff == LANG_ID_HIGH);
   assign ixh_bad    = (ixh_ff != 8'd0) &&
                       !(get_desc && kind_ff == DESC_STRING && ixh_ff == LANG_ID_HIGH &&
                         ix_ff == LANG_ID_LOW);

   assign c_desc_dev   = get_desc && ix_ff == 8'd0 && kind_ff == DESC_DEVICE && val_ff == 8'd0;
   assign c_desc_cfg   = get_desc && ix_ff == 8'd0 && kind_ff == DESC_CONFIG && val_ff == 8'd0;
   assign c_string     = get_desc && kind_ff == DESC_STRING && lang_ok && val_ff <= 8'd2;
   assign c_addr       = typ_ff == RT_DEV_OUT && req_ff == REQ_SET_ADDRESS && kind_ff == 8'd0 &&
                         !val_ff[7] && ix_ff == 8'd0 && wlen_ff == 16'd0 && !configured_ff;
   assign c_setcfg     = typ_ff == RT_DEV_OUT && req_ff == REQ_SET_CONFIG && kind_ff == 8'd0 &&
                         val_ff <= 8'd1 && ix_ff == 8'd0 && wlen_ff == 16'd0;
   assign c_getcfg     = typ_ff == RT_DEV_IN && req_ff == REQ_GET_CONFIG && plain_zero &&
                         ix_ff == 8'd0 && wlen_ff == 16'd1;
   assign c_stat_plain = req_ff == REQ_GET_STATUS && plain_zero && wlen_ff == 16'd2 &&
                         ((typ_ff == RT_DEV_IN && ix_ff == 8'd0) ||
                          (typ_ff == RT_IF_IN && configured_ff && iface_ok) ||
                          (typ_ff == RT_EP_IN && (ix_ff == 8'd0 || ix_ff == EP_ZERO_IN)));
   assign c_stat_ep    = req_ff == REQ_GET_STATUS && plain_zero && wlen_ff == 16'd2 &&
                         typ_ff == RT_EP_IN && configured_ff && ep_ok;
   assign c_feature    = configured_ff && typ_ff == RT_EP_OUT &&
                         (req_ff == REQ_CLEAR_FEATURE || req_ff == REQ_SET_FEATURE) &&
                         plain_zero && wlen_ff == 16'd0 && ep_ok;
   assign c_getif      = configured_ff && iface_ok && plain_zero && typ_ff == RT_IF_IN &&
                         req_ff == REQ_GET_IFACE && wlen_ff == 16'd1;
   assign c_setif      = configured_ff && iface_ok && plain_zero && typ_ff == RT_IF_OUT &&
                         req_ff == REQ_SET_IFACE && wlen_ff == 16'd0;
   assign c_fwd_hid    = typ_ff[4:0] == RT_RECIP_IF && hid_present_ff &&
                         ix_ff == (cdc_present_ff ? 8'd2 : 8'd0) &&
                         ((typ_ff == RT_IF_IN && req_ff == REQ_GET_DESC) || configured_ff);
   assign c_fwd_cdc    = typ_ff[4:0] == RT_RECIP_IF && cdc_present_ff && ix_ff == 8'd0 &&
                         configured_ff;

   // Decode of one word into the result and the next device state.
   logic        give;
   logic [7:0]  give_len;
   logic [2:0]  give_src;
   logic [15:0] give_word;

   always_comb begin
      give          = 1'b0;
      give_len      = 8'd0;
      give_src      = SRC_DEVICE;
      give_word     = 16'd0;
      action_in     = ACT_STALL;
      target_in     = CLASS_HID;
      addr_wr_in    = 1'b0;
      addr_in       = 7'd0;
      halt_upd_in   = HALT_NONE;
      halt_ep_in    = 4'd0;
      halt_dir_in   = 1'b0;
      configured_in = configured_ff;
      halt_in_in    = halt_in_ff;
      halt_out_in   = halt_out_ff;
      priority if (op_ff) begin
         action_in     = ACT_NONE;
         configured_in = 1'b0;
         halt_in_in    = 4'd0;
         halt_out_in   = 4'd0;
      end else if (ixh_bad) begin
         action_in = ACT_STALL;
      end else if (c_desc_dev) begin
         give     = 1'b1;
         give_src = SRC_DEVICE;
         give_len = LEN_DEVICE;
      end else if (c_desc_cfg) begin
         give     = 1'b1;
         give_src = SRC_CONFIG;
         give_len = config_len_ff;
      end else if (c_string) begin
         give = 1'b1;
         priority if (val_ff == 8'd0) begin
            give_src = SRC_LANGUAGE;
            give_len = LEN_LANGUAGE;
         end else if (val_ff == 8'd1) begin
            give_src = SRC_MANUF;
            give_len = LEN_MANUF;
         end else if (cdc_present_ff) begin
            give_src = SRC_CDC_PROD;
            give_len = LEN_CDC_PROD;
         end else begin
            give_src = SRC_HID_PROD;
            give_len = LEN_HID_PROD;
         end
      end else if (c_addr) begin
         action_in  = ACT_STATUS;
         addr_wr_in = 1'b1;
         addr_in    = val_ff[6:0];
      end else if (c_setcfg) begin
         action_in     = ACT_STATUS;
         configured_in = val_ff[0];
         halt_in_in    = 4'd0;
         halt_out_in   = 4'd0;
      end else if (c_getcfg) begin
         give      = 1'b1;
         give_src  = SRC_REPLY;
         give_len  = LEN_BYTE;
         give_word = {15'd0, configured_ff};
      end else if (c_stat_plain) begin
         give     = 1'b1;
         give_src = SRC_REPLY;
         give_len = LEN_WORD;
      end else if (c_stat_ep) begin
         give      = 1'b1;
         give_src  = SRC_REPLY;
         give_len  = LEN_WORD;
         give_word = {15'd0, ep_halted};
      end else if (c_feature) begin
         action_in   = ACT_STATUS;
         halt_upd_in = (req_ff == REQ_SET_FEATURE) ? HALT_SET : HALT_CLEAR;
         halt_ep_in  = ix_ff[3:0];
         halt_dir_in = ix_ff[7];
         if (ix_ff[7]) begin
            halt_in_in = (req_ff == REQ_SET_FEATURE) ? (halt_in_ff | ep_bit)
                                                     : (halt_in_ff & ~ep_bit);
         end else begin
            halt_out_in = (req_ff == REQ_SET_FEATURE) ? (halt_out_ff | ep_bit)
                                                      : (halt_out_ff & ~ep_bit);
         end
      end else if (c_getif) begin
         give     = 1'b1;
         give_src = SRC_REPLY;
         give_len = LEN_BYTE;
      end else if (c_setif) begin
         action_in = ACT_STATUS;
      end else if (c_fwd_hid) begin
         action_in = ACT_FORWARD;
         target_in = CLASS_HID;
      end else if (c_fwd_cdc) begin
         action_in = ACT_FORWARD;
         target_in = CLASS_CDC;
      end else begin
         action_in = ACT_STALL;
      end
   end

   // Send fields: length clamped to wLength, short-packet rule for the zlp flag.
   logic len_short;

   assign len_short = {8'd0, give_len} < wlen_ff;

   always_comb begin
      source_in = 3'd0;
      length_in = 8'd0;
      zlp_in    = 1'b0;
      word_in   = 16'd0;
      if (give) begin
         source_in = give_src;
         length_in = len_short ? give_len : wlen_ff[7:0];
         zlp_in    = len_short && is_packet_multiple(give_len);
         word_in   = give_word;
      end
   end

   // Device state advances once per decoded word.
   always_ff @(posedge clock) begin
      if (reset) begin
         configured_ff <= 1'b0;
         halt_in_ff    <= 4'd0;
         halt_out_ff   <= 4'd0;
      end else if (step) begin
         configured_ff <= configured_in;
         halt_in_ff    <= halt_in_in;
         halt_out_ff   <= halt_out_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         action_ff   <= give ? ACT_SEND : action_in;
         source_ff   <= source_in;
         length_ff   <= length_in;
         zlp_ff      <= zlp_in;
         word_ff     <= word_in;
         target_ff   <= target_in;
         addr_wr_ff  <= addr_wr_in;
         addr_ff     <= addr_in;
         halt_upd_ff <= halt_upd_in;
         halt_ep_ff  <= halt_ep_in;
         halt_dir_ff <= halt_dir_in;
         configured_out_ff <= configured_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_action        = action_ff;
   assign rsp_data_source   = source_ff;
   assign rsp_send_length   = length_ff;
   assign rsp_send_zlp      = zlp_ff;
   assign rsp_reply_word    = word_ff;
   assign rsp_class_target  = target_ff;
   assign rsp_address_write = addr_wr_ff;
   assign rsp_new_address   = addr_ff;
   assign rsp_halt_update   = halt_upd_ff;
   assign rsp_halt_endpoint = halt_ep_ff;
   assign rsp_halt_is_in    = halt_dir_ff;
   assign rsp_configured    = configured_out_ff;

   // A bus reset always leaves the device unconfigured.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == ACT_NONE |-> !rsp_configured)
      else $error("bus reset result reports a configured device");

   // Send fields stay clear unless data is sent.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action != ACT_SEND |->
         rsp_send_length == 8'd0 && !rsp_send_zlp && rsp_reply_word == 16'd0)
      else $error("send fields set on a result without data");

   // An address write is only taken by an unconfigured device, as a status stage.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_address_write |-> rsp_action == ACT_STATUS && !rsp_configured)
      else $error("address write outside the unconfigured state");

   // Halt updates happen only while configured, as a status stage.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_halt_update != HALT_NONE |-> rsp_action == ACT_STATUS && rsp_configured)
      else $error("halt update outside a configured status stage");

endmodule
